// ===== rtl/core/sptw_pkg.sv =====
package sptw_pkg;

  localparam int unsigned AdcBitsDef = 12;

  localparam int unsigned LogSteps = 28;
  localparam int unsigned MantW    = 31;
  localparam int unsigned LogLat   = LogSteps + 2;

  localparam logic [27:0] Ln2Q28 = 28'd186065279;

  localparam int unsigned Scale33M = 33000000;
  localparam int unsigned NumScale = 3300;
  localparam int unsigned FullScale = 2500;
  localparam int unsigned EncScale = 66000;
  localparam int unsigned MoistScale = 100;
  localparam int unsigned MoistFull = 3722;

  localparam logic signed [47:0] ShC1 = 48'sd90174774800;
  localparam logic signed [35:0] ShC2 = 36'sd24891903100;
  localparam logic signed [25:0] ShC3 = 26'sd20432139;
  localparam logic [55:0] TwoE16 = 56'd20000000000000000;

  localparam int unsigned SoilQb    = 18;
  localparam int unsigned EncQb     = 16;
  localparam logic [17:0] QSatLimit = 18'd92850;

  localparam logic signed [16:0] SoilInvalid = -17'sd9990;
  localparam logic signed [16:0] SoilMax     = 17'sd65535;
  localparam logic signed [16:0] SoilHot     = 17'sd3800;
  localparam logic [15:0] EncOffset = 16'd5000;
  localparam logic [15:0] ChargeHiQ = 16'd8700;
  localparam logic [6:0]  DryReset  = 7'd50;
  localparam logic [6:0]  MoistSat  = 7'd127;

  localparam int unsigned OutW = 48;

  function automatic logic signed [63:0] round20(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + 64'd524288) >> 20;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== rtl/core/sptw_dly.sv =====
module sptw_dly import sptw_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

// ===== rtl/core/sptw_log2.sv =====
module sptw_log2 import sptw_pkg::*; #(
  parameter  int unsigned XW = 37,
  localparam int unsigned EW = $clog2(XW)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [XW-1:0]    x_i,
  output logic [EW+27:0]   r_o
);

  logic [XW-1:0]    x_q;
  logic [EW-1:0]    e_d, e_q;
  logic [MantW-1:0] m_d;
  logic [MantW-1:0] m_q [LogSteps+1];
  logic [27:0]      f_q [LogSteps+1];
  logic [EW-1:0]    ex_q [LogSteps+1];
  logic [MantW-1:0] m_nx [LogSteps];
  logic [27:0]      f_nx [LogSteps];

  // top set bit
  always_comb begin
    e_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_i[i]) begin
        e_d = EW'(i);
      end
    end
  end

  // normalize mantissa to q30
  always_comb begin
    if (e_q >= EW'(30)) begin
      m_d = MantW'(x_q >> (e_q - EW'(30)));
    end else begin
      m_d = MantW'(x_q) << (EW'(30) - e_q);
    end
  end

  always_comb begin
    logic [2*MantW-1:0] sq;
    logic [MantW:0]     t;
    for (int s = 0; s < LogSteps; s++) begin
      sq = m_q[s] * m_q[s];
      t  = sq[2*MantW-1:MantW-1];
      m_nx[s] = t[MantW] ? t[MantW:1] : t[MantW-1:0];
      f_nx[s] = f_q[s] | ({27'd0, t[MantW]} << (LogSteps - 1 - s));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_i;
      e_q     <= e_d;
      m_q[0]  <= m_d;
      f_q[0]  <= '0;
      ex_q[0] <= e_q;
      for (int s = 0; s < LogSteps; s++) begin
        m_q[s+1]  <= m_nx[s];
        f_q[s+1]  <= f_nx[s];
        ex_q[s+1] <= ex_q[s];
      end
    end
  end

  assign r_o = {ex_q[LogSteps], f_q[LogSteps]};

endmodule

// ===== rtl/core/sptw_div.sv =====
module sptw_div import sptw_pkg::*; #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned QB = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  localparam int unsigned CW = NW + DW + QB;

  logic [NW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [NW-1:0] ri [QB];
  logic [DW-1:0] di [QB];
  logic [QB-1:0] qi [QB];
  logic [NW-1:0] r_nx [QB];
  logic [QB-1:0] q_nx [QB];

  always_comb begin
    ri[0] = num_i;
    di[0] = den_i;
    qi[0] = '0;
    for (int j = 1; j < QB; j++) begin
      ri[j] = rem_q[j-1];
      di[j] = den_q[j-1];
      qi[j] = quo_q[j-1];
    end
  end

  // one quotient bit per stage, msb first
  always_comb begin
    logic [CW-1:0] sh;
    for (int j = 0; j < QB; j++) begin
      sh = CW'(di[j]) << (QB - 1 - j);
      if (CW'(ri[j]) >= sh) begin
        r_nx[j] = NW'(CW'(ri[j]) - sh);
        q_nx[j] = qi[j] | (QB'(1) << (QB - 1 - j));
      end else begin
        r_nx[j] = ri[j];
        q_nx[j] = qi[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QB; j++) begin
        rem_q[j] <= r_nx[j];
        den_q[j] <= di[j];
        quo_q[j] <= q_nx[j];
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

// ===== rtl/core/soil_probe_temperature_and_watering_top.sv =====
// throughput: one word per cycle when not stalled, set by the fully pipelined log2 squaring
//   chain (28 stages per operand) and the 18-stage restoring divider
// the whole pipeline advances whenever the output register is empty or taken
// reset: async active low, clears valid bits and sets the dry threshold to 50
module soil_probe_temperature_and_watering_top import sptw_pkg::*; #(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // enclosure_adc, soil_temp_adc, moisture_adc
  input  logic [((3*ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // enclosure_centi_c, soil_centi_c, soil_reading_valid, moisture_pct,
  // water_request, charge_allowed
  output logic [OutW-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  localparam int unsigned AB      = ADC_BITS;
  localparam int unsigned AdcMax  = (1 << AB) - 1;
  localparam int unsigned X1W     = AB + 25;
  localparam int unsigned NUMW    = AB + 12;
  localparam int unsigned EW1     = $clog2(X1W);
  localparam int unsigned EW2     = $clog2(NUMW);
  localparam int unsigned RW      = EW1 + 28;
  localparam int unsigned PW      = RW + 28;
  localparam int unsigned LW      = 26;
  localparam int unsigned NEW     = AB + 17;
  localparam int unsigned NMW     = AB + 7;
  localparam int unsigned MQB     = (AB - 5 > 7) ? AB - 5 : 7;
  localparam int unsigned SoilLat = 1 + LogLat + 9 + SoilQb;
  localparam int unsigned EncDly  = SoilLat - 2;
  localparam int unsigned MstDly  = SoilLat - 2;
  localparam int unsigned EncK    = 2*AB + 18;
  localparam int unsigned MoistK  = AB + 19;
  localparam int unsigned PeW     = EncK + EncQb;
  localparam int unsigned PmW     = MoistK + MQB;
  localparam longint unsigned EncRc =
    ((64'd1 << EncK) + 64'(2 * AdcMax) - 64'd1) / 64'(2 * AdcMax);
  localparam longint unsigned MoistRc =
    ((64'd1 << MoistK) + 64'(MoistFull) - 64'd1) / 64'(MoistFull);
  localparam logic [NUMW-1:0] Full   = NUMW'(FullScale * AdcMax);

  logic en;
  logic [AB-1:0] ea, sa, ma;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign ea = s_axis_tdata[AB-1:0];
  assign sa = s_axis_tdata[2*AB-1:AB];
  assign ma = s_axis_tdata[3*AB-1:2*AB];

  // threshold register
  logic [6:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= DryReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // valid bits
  logic [SoilLat-1:0] vld_q;
  logic out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[SoilLat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[SoilLat-1];
    end
  end

  // front stage
  logic [NUMW-1:0] num;
  logic bad_d;
  logic [X1W-1:0]  x1_q;
  logic [NUMW-1:0] x2_q;
  logic            bad_q;
  logic [NEW-1:0]  ne_q;
  logic [NMW-1:0]  nm_q;

  assign num   = NUMW'(sa) * NUMW'(NumScale);
  assign bad_d = (sa == '0) || (num >= Full);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= (sa == '0) ? X1W'(1) : X1W'(sa) * X1W'(Scale33M);
      x2_q  <= bad_d ? NUMW'(1) : Full - num;
      bad_q <= bad_d;
      ne_q  <= NEW'(ea) * NEW'(EncScale) + NEW'(AdcMax);
      nm_q  <= NMW'(ma) * NMW'(MoistScale);
    end
  end

  // logs
  logic [EW1+27:0] r1;
  logic [EW2+27:0] r2;

  sptw_log2 #(.XW(X1W)) u_log_a (
    .clk_i(clk_i), .en_i(en), .x_i(x1_q), .r_o(r1)
  );
  sptw_log2 #(.XW(NUMW)) u_log_b (
    .clk_i(clk_i), .en_i(en), .x_i(x2_q), .r_o(r2)
  );

  // steinhart-hart polynomial
  logic signed [RW:0] dif;
  logic [PW:0]    lsum;
  logic [LW-2:0]  lmag;
  logic           neg_q;
  logic [RW-1:0]  mag_q;
  logic signed [LW-1:0]   l_q, l_k34, l_k35;
  logic signed [2*LW-1:0] sq_q;
  logic signed [31:0]     l2_q;
  logic signed [57:0]     p3_q;
  logic signed [61:0]     c2l_q;
  logic signed [37:0]     l3_q;
  logic signed [41:0]     c2t_q, c2t2_q;
  logic signed [63:0]     c3l_q;
  logic signed [47:0]     d_q;
  logic [55:0] nd_q;
  logic [46:0] vd_q;
  logic        ovf_q, inv_q;
  logic        bad_k39;

  assign dif  = $signed({1'b0, r1}) - $signed({1'b0, RW'(r2)});
  assign lsum = (PW+1)'((PW)'(mag_q) * (PW)'(Ln2Q28)) + ((PW+1)'(1) << 35);
  assign lmag = lsum[36 +: LW-1];

  sptw_dly #(.W(1), .DEPTH(LogLat + 8)) u_dly_bad (
    .clk_i(clk_i), .en_i(en), .d_i(bad_q), .q_o(bad_k39)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q  <= dif[RW];
      mag_q  <= dif[RW] ? RW'(-dif) : RW'(dif);
      l_q    <= neg_q ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
      sq_q   <= l_q * l_q;
      l_k34  <= l_q;
      l2_q   <= 32'(round20(64'(sq_q)));
      l_k35  <= l_k34;
      p3_q   <= l2_q * l_k35;
      c2l_q  <= ShC2 * l_k35;
      l3_q   <= 38'(round20(64'(p3_q)));
      c2t_q  <= 42'(round20(64'(c2l_q)));
      c3l_q  <= ShC3 * l3_q;
      c2t2_q <= c2t_q;
      d_q    <= ShC1 + 48'(c2t2_q) + 48'(round20(c3l_q));
      inv_q  <= bad_k39 || (d_q <= 48'sd0);
      nd_q   <= TwoE16 + 56'(d_q);
      vd_q   <= 47'(d_q) << 1;
      ovf_q  <= {10'd0, TwoE16 + 56'(d_q)} >= {1'b0, 47'(d_q) << 1, 18'd0};
    end
  end

  // dividers
  logic [SoilQb-1:0] qs;
  logic [EncQb-1:0]  qe, qe_d;
  logic [MQB-1:0]    qm, qm_d;
  logic              inv_s, ovf_s;
  logic [PeW-1:0]    pe_q;
  logic [PmW-1:0]    pm_q;

  sptw_div #(.NW(56), .DW(47), .QB(SoilQb)) u_div_soil (
    .clk_i(clk_i), .en_i(en), .num_i(nd_q), .den_i(vd_q), .quo_o(qs)
  );
  sptw_dly #(.W(2), .DEPTH(SoilQb)) u_dly_flg (
    .clk_i(clk_i), .en_i(en), .d_i({inv_q, ovf_q}), .q_o({inv_s, ovf_s})
  );

  // constant divides by reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (en) begin
      pe_q <= PeW'(ne_q) * PeW'(EncRc);
      pm_q <= PmW'(nm_q) * PmW'(MoistRc);
    end
  end

  assign qe = pe_q[PeW-1:EncK];
  assign qm = pm_q[PmW-1:MoistK];

  sptw_dly #(.W(EncQb), .DEPTH(EncDly)) u_dly_enc (
    .clk_i(clk_i), .en_i(en), .d_i(qe), .q_o(qe_d)
  );

  sptw_dly #(.W(MQB), .DEPTH(MstDly)) u_dly_mst (
    .clk_i(clk_i), .en_i(en), .d_i(qm), .q_o(qm_d)
  );

  // output stage
  logic signed [18:0] tq;
  logic signed [16:0] soil_d, soil_q;
  logic [6:0]  moist_d, moist_q;
  logic [15:0] enc_q;
  logic sval_q, water_q, chg_q;

  assign tq = $signed({1'b0, qs}) - 19'sd27315;

  always_comb begin
    if (inv_s) begin
      soil_d = SoilInvalid;
    end else if (ovf_s || (qs > QSatLimit)) begin
      soil_d = SoilMax;
    end else begin
      soil_d = tq[16:0];
    end
    moist_d = (qm_d > MQB'(MoistSat)) ? MoistSat : qm_d[6:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      enc_q   <= qe_d - EncOffset;
      soil_q  <= soil_d;
      sval_q  <= !inv_s;
      moist_q <= moist_d;
      water_q <= (moist_d < thr_q) || (!inv_s && (soil_d > SoilHot));
      chg_q   <= (qe_d >= EncOffset) && (qe_d <= ChargeHiQ);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, chg_q, water_q, moist_q, sval_q, soil_q, enc_q};

  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !sval_q |-> soil_q == SoilInvalid) else $error("invalid soil value");
  a_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sval_q && (soil_q > SoilHot) |-> water_q) else $error("hot soil not watered");
  a_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && chg_q |-> !enc_q[15] && ($signed(enc_q) <= 16'sd3700))
    else $error("charge outside range");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved while stalled");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sptw_pkg::*;

  localparam int unsigned AB = AdcBitsDef;
  localparam int unsigned InW = ((3*AB+7)/8)*8;
  localparam longint unsigned AdcMax = (64'd1 << AB) - 1;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic        charge;
    logic        water;
    logic [6:0]  moist;
    logic        valid;
    logic [16:0] soil;
    logic [15:0] enc;
  } probe_res_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [InW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [6:0] cfg_wdata_i;

  soil_probe_temperature_and_watering_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  logic [InW-1:0] pending_words[$];
  probe_res_t expected_res[$];
  logic [6:0] dry_pct;
  int errors, n_sent, n_recv, idle_cycles, burst_left, gap_left, stall_phase;
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint log2_q28(longint unsigned x);
    int e;
    longint unsigned m;
    longint r;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    r = longint'(e) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | (longint'(1) << i);
      end
    end
    return r;
  endfunction

  function automatic longint rnd20(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + 64'd524288) >> 20;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic probe_res_t predict_probe(logic [InW-1:0] w, logic [6:0] thr);
    probe_res_t r;
    longint unsigned ea, sa, ma, num, full, mag, moist;
    longint enc, soil, diff, l, l2, l3, d, t;
    bit ok;
    ea = w[AB-1:0];
    sa = w[2*AB-1:AB];
    ma = w[3*AB-1:2*AB];
    enc = longint'((ea * 66000 + AdcMax) / (2 * AdcMax)) - 5000;
    num = sa * 3300;
    full = 2500 * AdcMax;
    ok = 0;
    soil = -9990;
    if (sa != 0 && num < full) begin
      diff = log2_q28(10000 * num) - log2_q28(full - num);
      mag = (diff < 0) ? longint'(-diff) : diff;
      mag = (mag * 64'd186065279 + (64'd1 << 35)) >> 36;
      l = (diff < 0) ? -longint'(mag) : longint'(mag);
      l2 = rnd20(l * l);
      l3 = rnd20(l2 * l);
      d = 64'sd90174774800 + rnd20(64'sd24891903100 * l) + rnd20(64'sd20432139 * l3);
      if (d > 0) begin
        t = (64'sd20000000000000000 + d) / (2 * d) - 27315;
        if (t > 65535) t = 65535;
        if (t < -65536) t = -65536;
        soil = t;
        ok = 1;
      end
    end
    moist = ma * 100 / 3722;
    if (moist > 127) moist = 127;
    r.enc = enc[15:0];
    r.soil = soil[16:0];
    r.valid = ok;
    r.moist = moist[6:0];
    r.water = (moist < thr) || (ok && soil > 3800);
    r.charge = (enc >= 0) && (enc <= 3700);
    return r;
  endfunction

  function automatic logic [InW-1:0] pack_word(int e, int s, int m);
    logic [InW-1:0] w;
    w = '0;
    w[AB-1:0] = AB'(e);
    w[2*AB-1:AB] = AB'(s);
    w[3*AB-1:2*AB] = AB'(m);
    return w;
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(predict_probe(s_axis_tdata, dry_pct));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 64) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected word %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          automatic probe_res_t e = expected_res.pop_front();
          automatic probe_res_t a = m_axis_tdata[$bits(probe_res_t)-1:0];
          if (a.enc !== e.enc || a.soil !== e.soil || a.valid !== e.valid ||
              a.moist !== e.moist || a.water !== e.water || a.charge !== e.charge ||
              m_axis_tdata[OutW-1:$bits(probe_res_t)] !== '0) begin
            $display("%0t: mismatch expected enc=%0d soil=%0d v=%0b m=%0d w=%0b c=%0b",
                     $time, $signed(e.enc), $signed(e.soil), e.valid, e.moist,
                     e.water, e.charge);
            $display("%0t:          actual enc=%0d soil=%0d v=%0b m=%0d w=%0b c=%0b",
                     $time, $signed(a.enc), $signed(a.soil), a.valid, a.moist,
                     a.water, a.charge);
            errors <= errors + 1;
          end
        end
        n_recv <= n_recv + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (stim_done && expected_res.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [6:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dry_pct = v;
  endtask

  task automatic random_phase(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: pending_words.push_back(pack_word($urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 4095)));
        1: pending_words.push_back(pack_word($urandom_range(700, 1200),
             $urandom_range(1, 3100), $urandom_range(0, 4095)));
        2: pending_words.push_back(pack_word($urandom_range(0, 4095),
             $urandom_range(3090, 3102), $urandom_range(3600, 4095)));
        default: pending_words.push_back(pack_word($urandom_range(600, 800),
             $urandom_range(0, 200), $urandom_range(1500, 2300)));
      endcase
    end
  endtask

  initial begin
    int s_list[] = '{0, 1, 2, 100, 1024, 1500, 2048, 3000, 3101, 3102, 3103, 4094, 4095};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    dry_pct = DryReset;
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    stim_done = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (s_list[i]) pending_words.push_back(pack_word(s_list[i], s_list[i], s_list[i]));
    pending_words.push_back(pack_word(620, 2048, 3722));
    pending_words.push_back(pack_word(621, 1800, 3721));
    pending_words.push_back(pack_word(1079, 600, 1824));
    pending_words.push_back(pack_word(1080, 1000, 1861));
    pending_words.push_back(pack_word(4095, 4095, 0));
    pending_words.push_back(pack_word(0, 1, 4095));
    pending_words.push_back(pack_word(2730, 1365, 2730));
    drain();
    foreach (s_list[i]) begin
      write_threshold(7'(($urandom_range(0, 1) == 0) ? 0 : 127));
      pending_words.push_back(pack_word(s_list[i], $urandom_range(0, 4095), s_list[i]));
      drain();
    end
    drain();
    write_threshold(7'd0);
    random_phase(110);
    drain();
    write_threshold(7'd127);
    random_phase(110);
    drain();
    write_threshold(7'd100);
    random_phase(110);
    drain();
    write_threshold(7'($urandom_range(1, 99)));
    random_phase(110);
    drain();
    repeat (80) @(posedge clk_i);
    stim_done = 1;
    $display("sent %0d words, checked %0d results over several thresholds", n_sent, n_recv);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
